FILE: sv/fmfs_pkg.sv
// Shared definitions for the folded monochrome frame store and row scanout.
// Action codes, controller states and default panel size. No dependencies.
package fmfs_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  // command byte base: vertical/horizontal address set
  localparam logic [7:0] CMD_BASE = 8'h80;

  localparam logic [1:0] ACT_SET_PIXEL = 2'd0;
  localparam logic [1:0] ACT_CLR_PIXEL = 2'd1;
  localparam logic [1:0] ACT_CLR_STORE = 2'd2;
  localparam logic [1:0] ACT_FLUSH_ROW = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_CMD0,
    ST_CMD1,
    ST_DATA
  } fmfs_state_t;

endpackage

FILE: sv/fmfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies; contents are not reset.
module fmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/folded_mono_framebuffer_scanout.sv
// Folded monochrome frame store with row scanout; uses fmfs_pkg and fmfs_ram.
// Pixel set/clear: read-modify-write of one byte, read in ST_IDLE, written back in ST_RMW.
// Store clear: one byte written per cycle over all STORE_BYTES entries (1024 by default).
// Flush: first command byte is registered out of ST_CMD0 after accept, then one byte
//   per cycle while out_stall is low.
// Reset: clearing pass over all STORE_BYTES entries (1024) with in_stall high.
module folded_mono_framebuffer_scanout #(
  parameter int PANEL_WIDTH  = fmfs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = fmfs_pkg::PANEL_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [6:0] pixel_x,
  input  logic [5:0] pixel_y,
  input  logic [4:0] flush_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_command,
  output logic [7:0] bus_byte,
  output logic       last
);

  import fmfs_pkg::*;

  localparam int GD_COLS     = 2 * PANEL_WIDTH;
  localparam int GD_ROWS     = PANEL_HEIGHT / 2;
  localparam int ROW_BYTES   = (GD_COLS + 7) / 8;
  localparam int STORE_BYTES = GD_ROWS * ROW_BYTES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = $clog2(ROW_BYTES);

  fmfs_state_t state, state_next;

  logic [AW-1:0] addr, addr_next;
  logic [7:0]    mask, mask_next;
  logic          set_op, set_op_next;
  logic [4:0]    row, row_next;
  logic [CW-1:0] byte_idx, byte_idx_next;
  logic          out_valid_next, is_command_next, last_next;
  logic [7:0]    bus_byte_next;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // pixel location, folding the lower panel half to the right of the upper half
  logic          fold, pix_ok, row_ok, out_free, byte_last;
  logic [6:0]    gy;
  logic [8:0]    gx;
  logic [AW-1:0] pix_idx, row_base;

  always_comb begin
    fold    = int'(pixel_y) >= GD_ROWS;
    gy      = fold ? 7'(pixel_y) - 7'(GD_ROWS) : 7'(pixel_y);
    gx      = fold ? 9'(pixel_x) + 9'(PANEL_WIDTH) : 9'(pixel_x);
    pix_ok  = (int'(pixel_x) < PANEL_WIDTH) && (int'(pixel_y) < PANEL_HEIGHT) &&
              (int'(gy) < GD_ROWS);
    pix_idx = AW'(32'(gy) * 32'(ROW_BYTES) + 32'(gx[8:3]));
    row_ok  = int'(flush_row) < GD_ROWS;
    row_base = AW'(32'(flush_row) * 32'(ROW_BYTES));
  end

  assign out_free  = !out_valid || !out_stall;
  assign byte_last = byte_idx == CW'(ROW_BYTES - 1);

  fmfs_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    addr_next       = addr;
    mask_next       = mask;
    set_op_next     = set_op;
    row_next        = row;
    byte_idx_next   = byte_idx;
    out_valid_next  = out_valid && out_stall;
    is_command_next = is_command;
    bus_byte_next   = bus_byte;
    last_next       = last;
    in_stall        = state != ST_IDLE;
    ram_we          = 1'b0;
    ram_waddr       = addr;
    ram_wdata       = 8'h00;
    ram_re          = 1'b0;
    ram_raddr       = addr;

    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (addr == AW'(STORE_BYTES - 1)) begin
          addr_next  = '0;
          state_next = ST_IDLE;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_SET_PIXEL, ACT_CLR_PIXEL: begin
              if (pix_ok) begin
                ram_re      = 1'b1;
                ram_raddr   = pix_idx;
                addr_next   = pix_idx;
                mask_next   = 8'h80 >> gx[2:0];
                set_op_next = action == ACT_SET_PIXEL;
                state_next  = ST_RMW;
              end
            end
            ACT_CLR_STORE: begin
              addr_next  = '0;
              state_next = ST_CLEAR;
            end
            ACT_FLUSH_ROW: begin
              if (row_ok) begin
                addr_next  = row_base;
                row_next   = flush_row;
                state_next = ST_CMD0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        ram_we     = 1'b1;
        ram_wdata  = set_op ? (ram_rdata | mask) : (ram_rdata & ~mask);
        state_next = ST_IDLE;
      end
      ST_CMD0: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          is_command_next = 1'b1;
          bus_byte_next   = CMD_BASE | {3'b000, row};
          last_next       = 1'b0;
          state_next      = ST_CMD1;
        end
      end
      ST_CMD1: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          is_command_next = 1'b1;
          bus_byte_next   = CMD_BASE;
          last_next       = 1'b0;
          ram_re          = 1'b1;
          byte_idx_next   = '0;
          state_next      = ST_DATA;
        end
      end
      ST_DATA: begin
        // read data for byte_idx is ready; prefetch the next byte as it is taken
        if (out_free) begin
          out_valid_next  = 1'b1;
          is_command_next = 1'b0;
          bus_byte_next   = ram_rdata;
          last_next       = byte_last;
          if (byte_last) begin
            state_next = ST_IDLE;
          end else begin
            ram_re        = 1'b1;
            ram_raddr     = addr + 1'b1;
            addr_next     = addr + 1'b1;
            byte_idx_next = byte_idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      addr      <= addr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mask       <= mask_next;
    set_op     <= set_op_next;
    row        <= row_next;
    byte_idx   <= byte_idx_next;
    is_command <= is_command_next;
    bus_byte   <= bus_byte_next;
    last       <= last_next;
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  a_rmw_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && ram_re) |=> (state == ST_RMW && ram_we))
    else $error("pixel read not followed by write-back");

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> !is_command)
    else $error("last marked on a command byte");

  a_flush_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA) |-> (int'(addr) < STORE_BYTES))
    else $error("flush address beyond store");

endmodule
